@@ src/sbws_pkg.sv @@
// Package for the sparse Bayesian weight solver: codes, states and fixed-point helpers.
`timescale 1ns / 1ps
package sbws_pkg;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_Y = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;

	localparam logic [2:0] REG_WEIGHT_SHAPE = 3'd0;
	localparam logic [2:0] REG_WEIGHT_RATE  = 3'd1;
	localparam logic [2:0] REG_NOISE_SHAPE  = 3'd2;
	localparam logic [2:0] REG_NOISE_RATE   = 3'd3;
	localparam logic [2:0] REG_LIPSCHITZ    = 3'd4;
	localparam logic [2:0] REG_SWEEPS       = 3'd5;

	localparam logic signed [31:0] ONE_Q  = 32'sd65536;
	localparam int                 HALF_Q = 32768;
	localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

	typedef enum logic [1:0] {
		M_GRAM,
		M_RES1,
		M_GRAD,
		M_RES2
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DOTSET,
		S_DOT,
		S_DFIN,
		S_SQW,
		S_SQACC,
		S_INIT0,
		S_INIT0W,
		S_INIT1W,
		S_INIT2,
		S_SW0,
		S_SW0W,
		S_SW0R,
		S_U0,
		S_U1,
		S_U2,
		S_U3,
		S_U4,
		S_U5,
		S_U6,
		S_U7,
		S_U8,
		S_U9,
		S_U10,
		S_U11,
		S_U12,
		S_U13,
		S_LAM,
		S_LAMW,
		S_OUT0,
		S_OUT1,
		S_OUT2
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return Q_MAX;
		end else if (x < -64'sd2147483648) begin
			return Q_MIN;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [63:0] ext31(input logic [30:0] x);
		return $signed({33'd0, x});
	endfunction

endpackage

@@ src/sparse_bayes_weight_solver.sv @@
// Top level of the sparse Bayesian weight solver: loads, sequencer, shared multiplier and divider.
`timescale 1ns / 1ps
// Variational sparse Bayesian learning in Q16.16. Load items (tuser 0: matrix element,
// tuser 1: measurement) take one cycle each. A run item (tuser 2) blocks the input until
// all WEIGHT_COUNT results have been taken. One shared 32x32 multiplier and one
// radix-2 divider (48 steps plus start) do all multiplications and divisions. They
// first form the column sums of squares, then run the sweeps, then return the
// results. Zero divisors saturate.
module sparse_bayes_weight_solver #(
	parameter int WEIGHT_COUNT      = 64,
	parameter int MEASUREMENT_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row_index[6:0], column_index[12:7], value[44:13]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // weight_index[5:0], weight_mean[37:6], weight_variance[68:38]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import sbws_pkg::*;

	localparam int WA = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
	localparam int RA = (MEASUREMENT_COUNT > 1) ? $clog2(MEASUREMENT_COUNT) : 1;
	localparam int KW = (WA > RA) ? WA : RA;
	localparam int AA = (WEIGHT_COUNT * MEASUREMENT_COUNT > 1) ?
		$clog2(WEIGHT_COUNT * MEASUREMENT_COUNT) : 1;

	// configuration
	logic [30:0] w_shape_q, w_rate_q, n_shape_q, n_rate_q, lip_q;
	logic [15:0] sweeps_q;

	state_t state_q, state_d;
	mode_t  mode_q;

	logic [KW-1:0] o_q, k_q;
	logic [AA-1:0] aa_q;
	logic          busy_q, v1_q, l1_q, v2_q, l2_q;
	logic [15:0]   ctr_q;

	logic signed [63:0] acc_q, mess_q, trace_q, prod_q;
	logic signed [31:0] op_a_q, op_b_q, lt_q, noise_q, xi0_q, d_q, v_q;

	logic [5:0]         out_idx_q;
	logic signed [31:0] out_mean_q;
	logic [30:0]        out_var_q;
	logic               out_last_q, out_valid_q;

	// memories and registered read data
	logic signed [31:0] a_mem [WEIGHT_COUNT*MEASUREMENT_COUNT];
	logic signed [31:0] y_mem [MEASUREMENT_COUNT];
	logic signed [31:0] resid_mem [MEASUREMENT_COUNT];
	logic signed [31:0] gram_mem [WEIGHT_COUNT];
	logic signed [31:0] mean_mem [WEIGHT_COUNT];
	logic signed [31:0] var_mem [WEIGHT_COUNT];
	logic signed [31:0] prec_mem [WEIGHT_COUNT];
	logic signed [31:0] g_mem [WEIGHT_COUNT];
	logic signed [31:0] a_rd, y_rd, resid_rd, gram_rd, mean_rd, var_rd, prec_rd, g_rd;

	// divider
	logic               dv_busy_q, dv_done_q, dv_neg_q, dv_zero_q;
	logic [5:0]         dv_cnt_q;
	logic [31:0]        dv_rem_q, dv_den_q;
	logic [47:0]        dv_num_q;
	logic               dv_start;
	logic signed [31:0] dv_n, dv_d, dv_res;
	logic [32:0]        dv_trial;
	logic signed [63:0] dv_qs;

	// input fields
	logic [1:0]         in_cmd;
	logic [6:0]         in_row;
	logic [5:0]         in_col;
	logic signed [31:0] in_val;
	logic               in_acc;

	// comb helpers
	logic signed [63:0] pr_w;
	logic signed [31:0] qm, dot_sat, res1, res2, alpha, nu, half_l, ex2, beta, lam;
	logic signed [31:0] mul_a, mul_b;
	logic               k_last, o_last_w, o_last_r;

	// write strobes
	logic               a_we, y_we, gram_we, mean_we, var_we, prec_we, g_we, resid_we;
	logic signed [31:0] mean_wd, var_wd, prec_wd, resid_wd;
	logic [AA-1:0]      a_wa;
	logic [WA-1:0]      mean_ra;

	assign in_cmd = s_tuser;
	assign in_row = s_tdata[6:0];
	assign in_col = s_tdata[12:7];
	assign in_val = s_tdata[44:13];
	assign in_acc = s_tvalid && s_tready;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {3'd0, out_var_q, out_mean_q, out_idx_q};

	assign pr_w    = prod_q >>> 16;
	assign qm      = sat32(pr_w);
	assign dot_sat = sat32(acc_q);
	assign res1    = sat32(64'(dot_sat) - 64'(y_rd));
	assign res2    = sat32(64'(y_rd) - 64'(dot_sat));
	assign alpha   = sat32(ext31(w_shape_q) + 64'(HALF_Q));
	assign nu      = sat32(ext31(n_shape_q) + 64'(MEASUREMENT_COUNT * HALF_Q));
	assign half_l  = $signed({1'b0, 1'b0, lip_q[30:1]});
	assign ex2     = sat32(64'(qm) + 64'(v_q));
	assign beta    = sat32(ext31(w_rate_q) + 64'(ex2 >>> 1));
	assign lam     = sat32(ext31(n_rate_q) + 64'(sat32(mess_q) >>> 1)
		+ 64'(sat32(trace_q) >>> 1));

	assign o_last_w = (o_q == KW'(WEIGHT_COUNT - 1));
	assign o_last_r = (o_q == KW'(MEASUREMENT_COUNT - 1));
	assign k_last   = (mode_q == M_GRAM || mode_q == M_GRAD) ?
		(k_q == KW'(MEASUREMENT_COUNT - 1)) : (k_q == KW'(WEIGHT_COUNT - 1));

	assign a_wa    = AA'(32'(in_row) * WEIGHT_COUNT + 32'(in_col));
	assign mean_ra = (state_q == S_DOT) ? k_q[WA-1:0] : o_q[WA-1:0];

	// shared multiplier: streams memory data in dot loops, else takes the operand registers
	always_comb begin
		if (state_q == S_DOT) begin
			mul_a = a_rd;
			case (mode_q)
				M_GRAM:  mul_b = a_rd;
				M_GRAD:  mul_b = resid_rd;
				default: mul_b = mean_rd;
			endcase
		end else begin
			mul_a = op_a_q;
			mul_b = op_b_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// memories
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_wa] <= in_val;
		end
		a_rd <= a_mem[aa_q];
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[in_row[RA-1:0]] <= in_val;
		end
		y_rd <= y_mem[o_q[RA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (resid_we) begin
			resid_mem[o_q[RA-1:0]] <= resid_wd;
		end
		resid_rd <= resid_mem[k_q[RA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (gram_we) begin
			gram_mem[o_q[WA-1:0]] <= dot_sat;
		end
		gram_rd <= gram_mem[o_q[WA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mean_we) begin
			mean_mem[o_q[WA-1:0]] <= mean_wd;
		end
		mean_rd <= mean_mem[mean_ra];
	end

	always_ff @(posedge clk) begin
		if (var_we) begin
			var_mem[o_q[WA-1:0]] <= var_wd;
		end
		var_rd <= var_mem[o_q[WA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (prec_we) begin
			prec_mem[o_q[WA-1:0]] <= prec_wd;
		end
		prec_rd <= prec_mem[o_q[WA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			g_mem[o_q[WA-1:0]] <= dot_sat;
		end
		g_rd <= g_mem[o_q[WA-1:0]];
	end

	// radix-2 restoring divider on magnitudes, (n << 16) / d
	assign dv_trial = {dv_rem_q, dv_num_q[47]};
	assign dv_qs    = $signed({16'd0, dv_num_q});
	assign dv_res   = dv_zero_q ? (dv_neg_q ? Q_MIN : Q_MAX) :
		sat32(dv_neg_q ? -dv_qs : dv_qs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_done_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (dv_start) begin
			dv_done_q <= (dv_d == 32'sd0);
			dv_busy_q <= (dv_d != 32'sd0);
			dv_cnt_q  <= 6'd47;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 6'd1;
			if (dv_cnt_q == 6'd0) begin
				dv_busy_q <= 1'b0;
				dv_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv_start) begin
			dv_zero_q <= (dv_d == 32'sd0);
			dv_neg_q  <= (dv_d == 32'sd0) ? dv_n[31] : (dv_n[31] ^ dv_d[31]);
			dv_num_q  <= {(dv_n[31] ? (~dv_n + 32'd1) : dv_n), 16'd0};
			dv_den_q  <= dv_d[31] ? (~dv_d + 32'd1) : dv_d;
			dv_rem_q  <= '0;
		end else if (dv_busy_q) begin
			if (dv_trial >= {1'b0, dv_den_q}) begin
				dv_rem_q <= 32'(dv_trial - {1'b0, dv_den_q});
				dv_num_q <= {dv_num_q[46:0], 1'b1};
			end else begin
				dv_rem_q <= dv_trial[31:0];
				dv_num_q <= {dv_num_q[46:0], 1'b0};
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_shape_q <= 31'd65536;
			w_rate_q  <= 31'd65536;
			n_shape_q <= 31'd65536;
			n_rate_q  <= 31'd65536;
			lip_q     <= 31'd65536;
			sweeps_q  <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WEIGHT_SHAPE: w_shape_q <= cfg_data[30:0];
				REG_WEIGHT_RATE:  w_rate_q  <= cfg_data[30:0];
				REG_NOISE_SHAPE:  n_shape_q <= cfg_data[30:0];
				REG_NOISE_RATE:   n_rate_q  <= cfg_data[30:0];
				REG_LIPSCHITZ:    lip_q     <= cfg_data[30:0];
				REG_SWEEPS:       sweeps_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		dv_start = 1'b0;
		dv_n     = '0;
		dv_d     = '0;
		a_we     = 1'b0;
		y_we     = 1'b0;
		gram_we  = 1'b0;
		mean_we  = 1'b0;
		var_we   = 1'b0;
		prec_we  = 1'b0;
		g_we     = 1'b0;
		resid_we = 1'b0;
		mean_wd  = '0;
		var_wd   = ONE_Q;
		prec_wd  = xi0_q;
		resid_wd = res1;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						CMD_LOAD_A: a_we = (32'(in_row) < MEASUREMENT_COUNT)
							&& (32'(in_col) < WEIGHT_COUNT);
						CMD_LOAD_Y: y_we = (32'(in_row) < MEASUREMENT_COUNT);
						CMD_RUN:    state_d = S_DOTSET;
						default: ;
					endcase
				end
			end
			S_DOTSET: state_d = S_DOT;
			S_DOT: begin
				if (v2_q && l2_q) begin
					state_d = S_DFIN;
				end
			end
			S_DFIN: begin
				unique case (mode_q)
					M_GRAM: begin
						gram_we = 1'b1;
						state_d = o_last_w ? S_INIT0 : S_DOTSET;
					end
					M_RES1: begin
						resid_we = 1'b1;
						state_d  = S_DOTSET;
					end
					M_GRAD: begin
						g_we    = 1'b1;
						state_d = o_last_w ? S_U0 : S_DOTSET;
					end
					M_RES2: state_d = S_SQW;
					default: ;
				endcase
			end
			S_SQW:   state_d = S_SQACC;
			S_SQACC: state_d = o_last_r ? S_LAM : S_DOTSET;
			S_INIT0: begin
				dv_start = 1'b1;
				dv_n     = $signed({1'b0, w_shape_q});
				dv_d     = $signed({1'b0, w_rate_q});
				state_d  = S_INIT0W;
			end
			S_INIT0W: begin
				if (dv_done_q) begin
					dv_start = 1'b1;
					dv_n     = $signed({1'b0, n_shape_q});
					dv_d     = $signed({1'b0, n_rate_q});
					state_d  = S_INIT1W;
				end
			end
			S_INIT1W: begin
				if (dv_done_q) begin
					state_d = S_INIT2;
				end
			end
			S_INIT2: begin
				mean_we = 1'b1;
				var_we  = 1'b1;
				prec_we = 1'b1;
				if (o_last_w) begin
					state_d = (sweeps_q == 16'd0) ? S_OUT0 : S_SW0;
				end
			end
			S_SW0:  state_d = S_SW0W;
			S_SW0W: state_d = S_SW0R;
			S_SW0R: state_d = S_DOTSET;
			S_U0:   state_d = S_U1;
			S_U1: begin
				dv_start = 1'b1;
				dv_n     = ONE_Q;
				dv_d     = sat32(64'(prec_rd) + 64'(lt_q));
				state_d  = S_U2;
			end
			S_U2: state_d = S_U3;
			S_U3: state_d = S_U4;
			S_U4: begin
				if (dv_done_q) begin
					var_we  = 1'b1;
					var_wd  = dv_res;
					state_d = S_U5;
				end
			end
			S_U5: state_d = S_U6;
			S_U6: state_d = S_U7;
			S_U7: state_d = S_U8;
			S_U8: begin
				mean_we = 1'b1;
				mean_wd = qm;
				state_d = S_U9;
			end
			S_U9: state_d = S_U10;
			S_U10: begin
				dv_start = 1'b1;
				dv_n     = alpha;
				dv_d     = beta;
				state_d  = S_U11;
			end
			S_U11: state_d = S_U12;
			S_U12: state_d = S_U13;
			S_U13: begin
				if (dv_done_q) begin
					prec_we = 1'b1;
					prec_wd = dv_res;
					state_d = o_last_w ? S_DOTSET : S_U0;
				end
			end
			S_LAM: begin
				dv_start = 1'b1;
				dv_n     = nu;
				dv_d     = lam;
				state_d  = S_LAMW;
			end
			S_LAMW: begin
				if (dv_done_q) begin
					state_d = (17'(ctr_q) + 17'd1 == {1'b0, sweeps_q}) ? S_OUT0 : S_SW0;
				end
			end
			S_OUT0: state_d = S_OUT1;
			S_OUT1: state_d = S_OUT2;
			S_OUT2: begin
				if (m_tready) begin
					state_d = o_last_w ? S_IDLE : S_OUT0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// dot-loop pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			l1_q <= 1'b0;
			v2_q <= 1'b0;
			l2_q <= 1'b0;
		end else begin
			v1_q <= (state_q == S_DOT) && busy_q;
			l1_q <= (state_q == S_DOT) && busy_q && k_last;
			v2_q <= v1_q;
			l2_q <= l1_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_GRAM;
			o_q         <= '0;
			k_q         <= '0;
			aa_q        <= '0;
			busy_q      <= 1'b0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_cmd == CMD_RUN) begin
						mode_q <= M_GRAM;
						o_q    <= '0;
					end
				end
				S_DOTSET: begin
					k_q    <= '0;
					busy_q <= 1'b1;
					if (mode_q == M_GRAM || mode_q == M_GRAD) begin
						aa_q <= AA'(o_q);
					end
				end
				S_DOT: begin
					if (busy_q) begin
						k_q  <= k_q + KW'(1);
						aa_q <= aa_q + ((mode_q == M_GRAM || mode_q == M_GRAD) ?
							AA'(WEIGHT_COUNT) : AA'(1));
						if (k_last) begin
							busy_q <= 1'b0;
						end
					end
				end
				S_DFIN: begin
					case (mode_q)
						M_GRAM, M_GRAD: o_q <= o_last_w ? '0 : o_q + KW'(1);
						M_RES1: begin
							if (o_last_r) begin
								mode_q <= M_GRAD;
								o_q    <= '0;
							end else begin
								o_q <= o_q + KW'(1);
							end
						end
						default: ;
					endcase
				end
				S_SQACC: o_q <= o_last_r ? '0 : o_q + KW'(1);
				S_INIT2: begin
					o_q   <= o_last_w ? '0 : o_q + KW'(1);
					ctr_q <= '0;
				end
				S_SW0R: begin
					mode_q <= M_RES1;
					o_q    <= '0;
					aa_q   <= '0;
				end
				S_U13: begin
					if (dv_done_q) begin
						if (o_last_w) begin
							mode_q <= M_RES2;
							o_q    <= '0;
							aa_q   <= '0;
						end else begin
							o_q <= o_q + KW'(1);
						end
					end
				end
				S_LAMW: begin
					if (dv_done_q) begin
						ctr_q <= ctr_q + 16'd1;
						o_q   <= '0;
					end
				end
				S_OUT1: out_valid_q <= 1'b1;
				S_OUT2: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						o_q         <= o_q + KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_DOTSET: acc_q <= '0;
			S_DOT: begin
				if (v2_q) begin
					acc_q <= acc_q + pr_w;
				end
			end
			S_DFIN: begin
				if (mode_q == M_GRAD && o_last_w) begin
					trace_q <= '0;
				end
				op_a_q <= res2;
				op_b_q <= res2;
			end
			S_SQACC: mess_q <= mess_q + pr_w;
			S_INIT0W: begin
				if (dv_done_q) begin
					xi0_q <= dv_res;
				end
			end
			S_INIT1W: begin
				if (dv_done_q) begin
					noise_q <= dv_res;
				end
			end
			S_SW0: begin
				op_a_q <= half_l;
				op_b_q <= noise_q;
			end
			S_SW0R: lt_q <= qm;
			S_U1: begin
				op_a_q <= half_l;
				op_b_q <= mean_rd;
			end
			S_U3: d_q <= sat32(64'(qm) - 64'(g_rd));
			S_U4: begin
				if (dv_done_q) begin
					v_q    <= dv_res;
					op_a_q <= noise_q;
					op_b_q <= dv_res;
				end
			end
			S_U6: begin
				op_a_q <= qm;
				op_b_q <= d_q;
			end
			S_U8: begin
				op_a_q <= qm;
				op_b_q <= qm;
			end
			S_U10: begin
				op_a_q <= gram_rd;
				op_b_q <= v_q;
			end
			S_U12: trace_q <= trace_q + pr_w;
			S_U13: begin
				if (dv_done_q && o_last_w) begin
					mess_q <= '0;
				end
			end
			S_LAMW: begin
				if (dv_done_q) begin
					noise_q <= dv_res;
				end
			end
			S_OUT1: begin
				out_idx_q  <= 6'(o_q);
				out_mean_q <= mean_rd;
				out_var_q  <= var_rd[30:0];
				out_last_q <= o_last_w;
			end
			default: ;
		endcase
	end

endmodule

@@ verif/tb_sparse_bayes_weight_solver.sv @@
// Testbench for the sparse Bayesian weight solver: loads, configured runs and result checks.
`timescale 1ns / 1ps
module tb_sparse_bayes_weight_solver;
	import sbws_pkg::*;

	localparam int NW = 64;
	localparam int NM = 128;
	localparam int RESULT_HOLD = 3000;
	localparam int SETTLE = 50;

	typedef struct {
		logic [5:0]  index;
		logic [31:0] mean;
		logic [30:0] variance;
		logic        last;
	} weight_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	sparse_bayes_weight_solver uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model state of the solver
	int          mat [NM][NW];
	int          meas [NM];
	int          gram [NW];
	int          means [NW];
	int          vars [NW];
	int          precs [NW];
	int          bpoint [NW];
	int          grad [NW];
	int          resid [NM];
	int          noise_prec;
	logic [30:0] w_shape = 31'd65536, w_rate = 31'd65536;
	logic [30:0] n_shape = 31'd65536, n_rate = 31'd65536, lip = 31'd65536;
	logic [15:0] sweeps = 16'd100;

	weight_result_t expected_weights [$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int q_sat(longint x);
		if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'h8000_0000;
		return int'(x);
	endfunction

	function automatic longint q_prod(int a, int b);
		return (longint'(a) * longint'(b)) >>> 16;
	endfunction

	function automatic int q_mul(int a, int b);
		return q_sat(q_prod(a, b));
	endfunction

	function automatic int q_div(int n, int d);
		if (d == 0) return (n < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return q_sat((longint'(n) * 65536) / longint'(d));
	endfunction

	// resid = A x - y, or y - A x when negated
	task automatic form_residual(input int x [NW], input bit negate);
		longint acc;
		for (int r = 0; r < NM; r++) begin
			acc = 0;
			for (int j = 0; j < NW; j++) acc += q_prod(mat[r][j], x[j]);
			acc = longint'(q_sat(acc)) - longint'(meas[r]);
			resid[r] = q_sat(negate ? -acc : acc);
		end
	endtask

	task automatic solver_sweep(input int half_l, input int alpha, input int nu);
		longint acc, mess, trace, lam;
		int lt, v, d, u, ex2, beta;
		lt = q_mul(half_l, noise_prec);
		bpoint = means;
		form_residual(bpoint, 1'b0);
		for (int i = 0; i < NW; i++) begin
			acc = 0;
			for (int r = 0; r < NM; r++) acc += q_prod(mat[r][i], resid[r]);
			grad[i] = q_sat(acc);
		end
		for (int i = 0; i < NW; i++) begin
			v = q_div(ONE_Q, q_sat(longint'(precs[i]) + lt));
			d = q_sat(longint'(q_mul(half_l, bpoint[i])) - grad[i]);
			vars[i] = v;
			means[i] = q_mul(q_mul(noise_prec, v), d);
		end
		for (int i = 0; i < NW; i++) begin
			u = means[i];
			ex2 = q_sat(longint'(q_mul(u, u)) + vars[i]);
			beta = q_sat(longint'(w_rate) + (ex2 >>> 1));
			precs[i] = q_div(alpha, beta);
		end
		form_residual(means, 1'b1);
		mess = 0;
		trace = 0;
		for (int r = 0; r < NM; r++) mess += q_prod(resid[r], resid[r]);
		for (int i = 0; i < NW; i++) trace += q_prod(gram[i], vars[i]);
		lam = longint'(n_rate) + (q_sat(mess) >>> 1) + (q_sat(trace) >>> 1);
		noise_prec = q_div(nu, q_sat(lam));
	endtask

	task automatic solve_and_queue();
		longint acc;
		int init_xi, alpha, nu, half_l;
		weight_result_t res;
		for (int i = 0; i < NW; i++) begin
			acc = 0;
			for (int r = 0; r < NM; r++) acc += q_prod(mat[r][i], mat[r][i]);
			gram[i] = q_sat(acc);
		end
		init_xi = q_div(int'(w_shape), int'(w_rate));
		for (int i = 0; i < NW; i++) begin
			means[i] = 0;
			vars[i] = ONE_Q;
			precs[i] = init_xi;
		end
		noise_prec = q_div(int'(n_shape), int'(n_rate));
		alpha = q_sat(longint'(w_shape) + HALF_Q);
		nu = q_sat(longint'(n_shape) + longint'(NM) * HALF_Q);
		half_l = int'(lip >> 1);
		for (int s = 0; s < sweeps; s++) solver_sweep(half_l, alpha, nu);
		for (int i = 0; i < NW; i++) begin
			res.index = i[5:0];
			res.mean = means[i];
			res.variance = vars[i][30:0];
			res.last = (i == NW - 1);
			expected_weights.push_back(res);
		end
	endtask

	task automatic send_item(input logic [1:0] cmd, input int row, input int col, input int val);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'd0, val[31:0], col[5:0], row[6:0]};
		do @(posedge clk); while (!s_tready);
		case (cmd)
			CMD_LOAD_A: mat[row][col] = val;
			CMD_LOAD_Y: meas[row] = val;
			CMD_RUN: solve_and_queue();
			default: ;
		endcase
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// block is idle once all results are back and trailing loads have drained
	task automatic wait_idle();
		while (expected_weights.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WEIGHT_SHAPE: w_shape = data[30:0];
			REG_WEIGHT_RATE: w_rate = data[30:0];
			REG_NOISE_SHAPE: n_shape = data[30:0];
			REG_NOISE_RATE: n_rate = data[30:0];
			REG_LIPSCHITZ: lip = data[30:0];
			REG_SWEEPS: sweeps = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] ws, input logic [31:0] wr, input logic [31:0] ns,
			input logic [31:0] nr, input logic [31:0] l, input logic [31:0] sw);
		write_reg(REG_WEIGHT_SHAPE, ws);
		write_reg(REG_WEIGHT_RATE, wr);
		write_reg(REG_NOISE_SHAPE, ns);
		write_reg(REG_NOISE_RATE, nr);
		write_reg(REG_LIPSCHITZ, l);
		write_reg(REG_SWEEPS, sw);
	endtask

	function automatic int small_value();
		return int'($urandom_range(131072)) - 65536;
	endfunction

	function automatic int load_value();
		if ($urandom_range(9) == 0) return int'($urandom);
		if ($urandom_range(3) == 0) return 0;
		return small_value();
	endfunction

	task automatic set_idle(input int mode);
		case (mode)
			0: begin send_idle = 29; recv_idle = 84; end
			1: begin send_idle = 84; recv_idle = 29; end
			default: begin send_idle = 0; recv_idle = 0; end
		endcase
	endtask

	// every matrix and measurement entry gets written before any run reads them
	task automatic test_fill_stores();
		set_idle(2);
		for (int r = 0; r < NM; r++) begin
			for (int c = 0; c < NW; c++) send_item(CMD_LOAD_A, r, c, load_value());
			send_item(CMD_LOAD_Y, r, 0, small_value());
		end
		stop_sending();
	endtask

	task automatic test_zero_sweeps();
		wait_idle();
		// upper data bits dropped: sweep count becomes zero
		set_all(32'h8001_0000, 32'h8001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'hFFFF_0000);
		write_reg(3'd7, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'h0);
		send_item(CMD_RUN, 0, 0, 0);
		stop_sending();
	endtask

	task automatic test_directed_extremes();
		set_idle(0);
		wait_idle();
		send_item(CMD_LOAD_A, 0, 0, 32'h8000_0000);
		send_item(CMD_LOAD_A, 127, 63, 32'h7FFF_FFFF);
		send_item(CMD_LOAD_A, 64, 31, -1);
		send_item(CMD_LOAD_Y, 127, 63, 32'h7FFF_FFFF);
		send_item(CMD_LOAD_Y, 0, 0, 32'h8000_0000);
		send_item(CMD_LOAD_Y, 1, 0, -1);
		send_item(2'd3, 127, 63, 32'hFFFF_FFFF);
		send_item(2'd3, 0, 0, 0);
		stop_sending();
		wait_idle();
		write_reg(REG_SWEEPS, 32'h0000_FFFF);
		set_all(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001,
			32'h7FFF_FFFF, 32'h0000_0001);
		send_item(CMD_RUN, 0, 0, 0);
		stop_sending();
		wait_idle();
		// zero rates: divisions saturate; zero shapes
		set_all(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h1, 32'h1);
		send_item(CMD_RUN, 5, 7, 0);
		stop_sending();
		wait_idle();
		// put the extreme entries back to ordinary values
		send_item(CMD_LOAD_A, 0, 0, small_value());
		send_item(CMD_LOAD_A, 127, 63, small_value());
		send_item(CMD_LOAD_Y, 127, 0, small_value());
		send_item(CMD_LOAD_Y, 0, 0, small_value());
		stop_sending();
	endtask

	task automatic test_random_phases();
		int n;
		for (int ph = 0; ph < 5; ph++) begin
			set_idle(ph % 3);
			wait_idle();
			set_all($urandom_range(32'h0004_0000, 32'h0000_8000),
				$urandom_range(32'h0004_0000, 32'h0000_4000),
				$urandom_range(32'h0004_0000, 32'h0000_8000),
				$urandom_range(32'h0004_0000, 32'h0000_4000),
				$urandom_range(32'h0010_0000, 32'h0001_0000),
				$urandom_range(2, 1));
			n = $urandom_range(90, 70);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(19) == 0)
					send_item(2'd3, $urandom_range(127), $urandom_range(63), $urandom);
				else if ($urandom_range(7) == 0)
					send_item(CMD_LOAD_Y, $urandom_range(127), $urandom_range(63),
						load_value());
				else
					send_item(CMD_LOAD_A, $urandom_range(127), $urandom_range(63),
						load_value());
			end
			send_item(CMD_RUN, $urandom_range(127), $urandom_range(63), $urandom);
			stop_sending();
		end
	endtask

	// receiver holds off on the first result while a load waits behind the run
	task automatic test_result_backpressure();
		set_idle(2);
		wait_idle();
		write_reg(REG_SWEEPS, 32'h1);
		hold_req = 1;
		send_item(CMD_RUN, 0, 0, 0);
		for (int k = 0; k < 30; k++)
			send_item(CMD_LOAD_A, $urandom_range(127), $urandom_range(63), small_value());
		stop_sending();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done && m_tvalid) begin
			m_tready <= 1'b0;
			hold_left <= RESULT_HOLD;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		weight_result_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_weights.size() == 0) begin
				$error("unexpected result: weight_index %0d", m_tdata[5:0]);
				errors++;
			end else begin
				exp_w = expected_weights.pop_front();
				if (m_tdata[5:0] !== exp_w.index) begin
					$error("weight_index: expected %0d, actual %0d", exp_w.index, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[37:6] !== exp_w.mean) begin
					$error("weight_mean: expected %0d, actual %0d", $signed(exp_w.mean),
						$signed(m_tdata[37:6]));
					errors++;
				end
				if (m_tdata[68:38] !== exp_w.variance) begin
					$error("weight_variance: expected %0d, actual %0d", exp_w.variance,
						m_tdata[68:38]);
					errors++;
				end
				if (m_tlast !== exp_w.last) begin
					$error("last: expected %0d, actual %0d", exp_w.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NW; i++) begin
			gram[i] = 0;
			means[i] = 0;
			vars[i] = ONE_Q;
			precs[i] = 0;
		end
		noise_prec = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_zero_sweeps();
		test_directed_extremes();
		test_random_phases();
		test_result_backpressure();
		while (expected_weights.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && expected_weights.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/sbws_pkg.sv
src/sparse_bayes_weight_solver.sv
verif/tb_sparse_bayes_weight_solver.sv
